// File: sv/keyed_score_table_top_macros.svh
// Assertion helpers used by the checker file of the keyed score table.
`ifndef KEYED_SCORE_TABLE_TOP_MACROS_SVH
`define KEYED_SCORE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define KST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kst_pkg.sv
`default_nettype none

package kst_pkg;

    // Operation codes. The unused code is served like a lookup.
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned SCORE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // One table entry as it sits in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [LEN_W-1:0]          len;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/kst_ram.sv
`default_nettype none

module kst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/keyed_score_table_top.sv
`default_nettype none

// Keyed score table: up to CAPACITY key and score pairs held in insertion order.
// A transaction is accepted at a rising edge where start is high and busy is low;
// opcode selects lookup, insert or delete (the unused code acts as a lookup) on the
// key given by key_text and key_length. Exactly one result follows each transaction:
// result_valid is high for one cycle while score_out, found, status, entry_count,
// is_full and is_empty carry it. The receiver cannot stall, so no result is held.
// Operation: all entries live in one memory with a registered read port, and the scan
// reads one entry per cycle. A search stops at its first hit or after the last
// entry (on an empty table the first step is a miss). A delete then copies every
// later entry down one place, one per cycle over the same port. The result strobe
// comes in the cycle after the last scan or copy cycle. A new transaction may be
// accepted in the cycle that shows the result, so transactions never overlap: the
// block takes a new one only when it is through with the last.
// Reset clears the entry count and returns to idle at once; the memory contents are
// left as they are, since only entries below the count are ever used.

module keyed_score_table_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         opcode,
    input  wire logic [kst_pkg::KEY_W-1:0]          key_text,
    input  wire logic [kst_pkg::LEN_W-1:0]          key_length,
    input  wire logic signed [kst_pkg::SCORE_W-1:0] new_score,
    output logic                                    result_valid,
    output logic signed [kst_pkg::SCORE_W-1:0]      score_out,
    output logic                                    found,
    output logic [1:0]                              status,
    output logic [kst_pkg::COUNT_W-1:0]             entry_count,
    output logic                                    is_full,
    output logic                                    is_empty
);

    import kst_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t            state_reg,  state_next;
    logic [AW-1:0]     idx_reg,    idx_next;
    logic [CW-1:0]     count_reg,  count_next;
    op_t               op_reg,     op_next;
    entry_t            req_reg,    req_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic              found_reg,  found_next;
    status_t           status_reg, status_next;
    logic              valid_reg,  valid_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    entry_t            mem_rdata;

    logic [EW-1:0]     idx_ext;
    logic [EW-1:0]     count_ext;
    logic              hit;
    logic              miss;
    logic              has_room;

    kst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_ext   = EW'(idx_reg);
    assign count_ext = EW'(count_reg);
    assign has_room  = (count_ext < EW'(CAPACITY));

    // The entry at idx_reg is on the read port during every scan cycle.
    assign hit  = (count_reg != '0)
               && (mem_rdata.key == req_reg.key)
               && (mem_rdata.len == req_reg.len);
    assign miss = !hit && ((idx_ext + EW'(1)) >= count_ext);

    // Read port: the scan fetches one entry ahead; the shift fetches the entry
    // after the one that moves down in this cycle.
    always_comb
    begin
        mem_raddr = '0;
        if (state_reg == S_SCAN)
        begin
            mem_raddr = AW'(idx_ext + EW'(1));
        end
        else if (state_reg == S_SHIFT)
        begin
            mem_raddr = AW'(idx_ext + EW'(2));
        end
    end

    // Write port: a shift moves entry idx+1 down to idx; an insert appends.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        if (state_reg == S_SHIFT)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_SCAN) && miss && (op_reg == OP_INSERT) && has_room)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_reg);
            mem_wdata = req_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        req_next    = req_reg;
        score_next  = score_reg;
        found_next  = found_reg;
        status_next = status_reg;
        valid_next  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next       = op_t'(opcode);
                    req_next.key  = key_text;
                    req_next.len  = key_length;
                    req_next.score = new_score;
                    idx_next      = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    score_next = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            status_next = ST_PRESENT;
                            valid_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                        OP_DELETE:
                        begin
                            status_next = ST_DONE;
                            if ((idx_ext + EW'(1)) < count_ext)
                            begin
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                valid_next = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            score_next  = mem_rdata.score;
                            status_next = ST_DONE;
                            valid_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                    endcase
                end
                else if (miss)
                begin
                    found_next  = 1'b0;
                    score_next  = '0;
                    status_next = ST_ABSENT;
                    if (op_reg == OP_INSERT)
                    begin
                        if (has_room)
                        begin
                            status_next = ST_DONE;
                            count_next  = count_reg + CW'(1);
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_SHIFT:
            begin
                if ((idx_ext + EW'(2)) < count_ext)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        req_reg    <= req_next;
        score_reg  <= score_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign score_out    = score_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign entry_count  = COUNT_W'(count_reg);
    assign is_full      = (count_ext == EW'(CAPACITY));
    assign is_empty     = (count_reg == '0);

endmodule

`default_nettype wire

// File: sv/kst_checker.sv
`default_nettype none

`include "keyed_score_table_top_macros.svh"

module kst_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic                               result_valid,
    input  wire logic                               found,
    input  wire logic [1:0]                         status,
    input  wire logic                               is_full
);

    import kst_pkg::*;

    // An accepted transaction always takes the block out of idle.
    `KST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

    // The result strobe comes only once the work is over.
    `KST_ASSERT_NOW(a_valid_idle, result_valid, !busy, "result shown while busy")

    // The block is idle whenever the strobe is shown, so strobes never touch.
    `KST_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid, "result strobe held two cycles")

    // A rejected insert leaves a full table behind.
    `KST_ASSERT_NOW(a_full_reject, result_valid && (status == ST_FULL), is_full,
        "full status without a full table")

    // A duplicate key report implies the key was found.
    `KST_ASSERT_NOW(a_present_found, result_valid && (status == ST_PRESENT), found,
        "present status without found")

endmodule

bind keyed_score_table_top kst_checker u_kst_checker (.*);

`default_nettype wire

// File: sim/keyed_score_table_checker.sv
`timescale 1ns / 100ps

// Watches the command and result ports of the keyed score table, keeps its own
// copy of the table and checks every result against the oldest outstanding one.
module keyed_score_table_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic [kst_pkg::KEY_W-1:0]          key_text,
    input  logic [kst_pkg::LEN_W-1:0]          key_length,
    input  logic signed [kst_pkg::SCORE_W-1:0] new_score,
    input  logic                               result_valid,
    input  logic signed [kst_pkg::SCORE_W-1:0] score_out,
    input  logic                               found,
    input  logic [1:0]                         status,
    input  logic [kst_pkg::COUNT_W-1:0]        entry_count,
    input  logic                               is_full,
    input  logic                               is_empty,
    output int unsigned                        error_count,
    output int unsigned                        pending_count
);

    import kst_pkg::*;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic                      found;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic                      full;
        logic                      empty;
    } table_reply_t;

    logic [KEY_W-1:0]          held_key   [CAPACITY];
    logic [LEN_W-1:0]          held_len   [CAPACITY];
    logic signed [SCORE_W-1:0] held_score [CAPACITY];
    int unsigned               held_total;

    table_reply_t expected_replies[$];
    table_reply_t oldest;
    int unsigned  mismatches;

    assign error_count = mismatches;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one transaction to the shadow table and returns the reply it earns.
    function automatic table_reply_t apply_table_op(input logic [1:0] op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic signed [SCORE_W-1:0] score);
        table_reply_t reply;
        int unsigned  slot;
        logic         hit;
        slot = held_total;
        hit  = 1'b0;
        for (int unsigned i = 0; i < held_total; i++)
        begin
            if (!hit && held_key[i] == key && held_len[i] == len)
            begin
                slot = i;
                hit  = 1'b1;
            end
        end
        reply.score = '0;
        reply.found = hit;
        if (op == OP_INSERT)
        begin
            if (hit)
            begin
                reply.status = ST_PRESENT;
            end
            else if (held_total >= CAPACITY)
            begin
                reply.status = ST_FULL;
            end
            else
            begin
                held_key[held_total]   = key;
                held_len[held_total]   = len;
                held_score[held_total] = score;
                held_total++;
                reply.status = ST_DONE;
            end
        end
        else if (op == OP_DELETE)
        begin
            if (hit)
            begin
                // Later entries move down one place so insertion order survives.
                for (int unsigned j = slot; j + 1 < held_total; j++)
                begin
                    held_key[j]   = held_key[j + 1];
                    held_len[j]   = held_len[j + 1];
                    held_score[j] = held_score[j + 1];
                end
                held_total--;
                reply.status = ST_DONE;
            end
            else
            begin
                reply.status = ST_ABSENT;
            end
        end
        else
        begin
            if (hit)
            begin
                reply.score  = held_score[slot];
                reply.status = ST_DONE;
            end
            else
            begin
                reply.status = ST_ABSENT;
            end
        end
        reply.count = COUNT_W'(held_total);
        reply.full  = (held_total == CAPACITY);
        reply.empty = (held_total == 0);
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_total = 0;
            expected_replies.delete();
            pending_count <= 0;
        end
        else
        begin
            // A result and a new transaction may share an edge; the result
            // belongs to an earlier transaction, so it is checked first.
            if (result_valid)
            begin
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("result with no transaction outstanding", '0, '0);
                end
                else
                begin
                    oldest = expected_replies.pop_front();
                    if (score_out !== oldest.score)
                        report_mismatch("score_out", 64'(score_out), 64'(oldest.score));
                    if (found !== oldest.found)
                        report_mismatch("found", 64'(found), 64'(oldest.found));
                    if (status !== oldest.status)
                        report_mismatch("status", 64'(status), 64'(oldest.status));
                    if (entry_count !== oldest.count)
                        report_mismatch("entry_count", 64'(entry_count), 64'(oldest.count));
                    if (is_full !== oldest.full)
                        report_mismatch("is_full", 64'(is_full), 64'(oldest.full));
                    if (is_empty !== oldest.empty)
                        report_mismatch("is_empty", 64'(is_empty), 64'(oldest.empty));
                end
            end
            if (start && !busy)
                expected_replies.push_back(apply_table_op(opcode, key_text, key_length,
                                                          new_score));
            pending_count <= expected_replies.size();
        end
    end

endmodule

// File: sim/keyed_score_table_top_test.sv
`timescale 1ns / 100ps

// Top of the keyed score table test. It resets the block once, then sends a
// short directed sequence followed by about 1400 random transactions, with
// random idle gaps between them. The checker beside the block predicts every
// result and counts mismatches; this module only makes stimulus and decides
// the verdict.
module keyed_score_table_top_test;

    import kst_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned RANDOM_OPS  = 1400;

    // The block serves the spare operation code like a lookup.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      start        = 1'b0;
    logic [1:0]                opcode       = '0;
    logic [KEY_W-1:0]          key_text     = '0;
    logic [LEN_W-1:0]          key_length   = '0;
    logic signed [SCORE_W-1:0] new_score    = '0;
    logic                      busy;
    logic                      result_valid;
    logic signed [SCORE_W-1:0] score_out;
    logic                      found;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_full;
    logic                      is_empty;
    int unsigned               error_count;
    int unsigned               pending_count;

    // Keys that random transactions draw from. There are more of them than
    // the table holds, so fill-heavy stretches run into a full table.
    logic [KEY_W-1:0] pool_text [POOL_SIZE];
    logic [LEN_W-1:0] pool_len  [POOL_SIZE];

    // Keys of the directed fill, built so that all sixteen are distinct.
    logic [KEY_W-1:0] fill_text [TABLE_DEPTH];
    logic [LEN_W-1:0] fill_len  [TABLE_DEPTH];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    keyed_score_table_top #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key_text    (key_text),
        .key_length  (key_length),
        .new_score   (new_score),
        .result_valid(result_valid),
        .score_out   (score_out),
        .found       (found),
        .status      (status),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

    keyed_score_table_checker #(
        .CAPACITY(TABLE_DEPTH)
    ) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_text     (key_text),
        .key_length   (key_length),
        .new_score    (new_score),
        .result_valid (result_valid),
        .score_out    (score_out),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count),
        .is_full      (is_full),
        .is_empty     (is_empty),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    // Presents one transaction and holds it until the block takes it. Busy is
    // read right after the edge, so it still shows the value the edge saw.
    // Start is left high; the caller lowers it only when a gap follows.
    task automatic issue(input logic [1:0] op, input logic [KEY_W-1:0] text,
                         input logic [LEN_W-1:0] len,
                         input logic signed [SCORE_W-1:0] score);
        opcode     <= op;
        key_text   <= text;
        key_length <= len;
        new_score  <= score;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle(input int unsigned cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stops sending until the checker holds no outstanding transaction. The
    // first edge lets the count include the transaction just accepted.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Most scores are random words; some are the signed extremes.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int unsigned roll;
        roll = $urandom_range(0, 39);
        case (roll)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Chooses an operation. Mode 0 favors inserts so the table fills up,
    // mode 1 favors deletes so it empties, and mode 2 is an even mix.
    function automatic logic [1:0] pick_op(input int unsigned mode);
        int unsigned roll;
        int unsigned ins_w;
        int unsigned del_w;
        roll = $urandom_range(0, 99);
        ins_w = (mode == 0) ? 55 : (mode == 1) ? 20 : 35;
        del_w = (mode == 0) ? 12 : (mode == 1) ? 50 : 25;
        if (roll < 5)
            return OP_UNUSED;
        else if (roll < 5 + ins_w)
            return OP_INSERT;
        else if (roll < 5 + ins_w + del_w)
            return OP_DELETE;
        else
            return OP_LOOKUP;
    endfunction

    // Most keys come straight from the pool so hits are common. The rest are
    // near misses (one text bit or one length bit changed, which must never
    // match) and fully random keys that exercise every bit of both fields.
    task automatic pick_key(output logic [KEY_W-1:0] text, output logic [LEN_W-1:0] len);
        int unsigned roll;
        int unsigned idx;
        roll = $urandom_range(0, 99);
        idx  = $urandom_range(0, POOL_SIZE - 1);
        text = pool_text[idx];
        len  = pool_len[idx];
        if (roll >= 94)
        begin
            text = {$urandom, $urandom};
            len  = LEN_W'($urandom_range(0, 15));
        end
        else if (roll >= 88)
        begin
            len = len ^ (LEN_W'(1) << $urandom_range(0, LEN_W - 1));
        end
        else if (roll >= 80)
        begin
            text = text ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] text;
        logic [LEN_W-1:0] len;
        int unsigned      block;

        // Pool keys look like words: lowercase letters packed from the low
        // byte with zero padding. Every sixth one carries loose bytes above
        // its length, which still take part in the comparison.
        for (int unsigned i = 0; i < POOL_SIZE; i++)
        begin
            pool_len[i] = LEN_W'($urandom_range(0, 8));
            if (i % 6 == 5)
            begin
                pool_text[i] = {$urandom, $urandom};
            end
            else
            begin
                pool_text[i] = '0;
                for (int unsigned b = 0; b < pool_len[i]; b++)
                    pool_text[i][8*b +: 8] = 8'($urandom_range(97, 122));
            end
        end

        // Directed fill keys: the empty key, an all-ones key at the longest
        // legal length, the same text with the largest length the field
        // holds, and then keys made distinct by their upper word.
        for (int unsigned i = 0; i < TABLE_DEPTH; i++)
        begin
            fill_text[i] = {32'(i), 32'($urandom)};
            fill_len[i]  = LEN_W'(i % 9);
        end
        fill_text[0] = '0;
        fill_len[0]  = '0;
        fill_text[1] = '1;
        fill_len[1]  = 4'd8;
        fill_text[2] = '1;
        fill_len[2]  = '1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookup, delete and the spare code on an empty table.
        issue(OP_LOOKUP, fill_text[3], fill_len[3], pick_score());
        issue(OP_DELETE, fill_text[3], fill_len[3], pick_score());
        issue(OP_UNUSED, fill_text[0], fill_len[0], pick_score());

        // Fill the table exactly, carrying the score extremes along.
        for (int unsigned i = 0; i < TABLE_DEPTH; i++)
        begin
            case (i)
                1:       issue(OP_INSERT, fill_text[i], fill_len[i], 32'sh7FFF_FFFF);
                2:       issue(OP_INSERT, fill_text[i], fill_len[i], 32'sh8000_0000);
                3:       issue(OP_INSERT, fill_text[i], fill_len[i], '0);
                4:       issue(OP_INSERT, fill_text[i], fill_len[i], -32'sd1);
                default: issue(OP_INSERT, fill_text[i], fill_len[i], $urandom);
            endcase
            idle(pick_gap());
        end

        // A new key into the full table is refused, while a key already held
        // reports that it is present, since presence is checked first.
        issue(OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd8, pick_score());
        issue(OP_INSERT, fill_text[5], fill_len[5], pick_score());
        // The last entry costs the longest scan; the two all-ones keys differ
        // only in length and must return their own scores.
        issue(OP_LOOKUP, fill_text[TABLE_DEPTH-1], fill_len[TABLE_DEPTH-1], pick_score());
        issue(OP_LOOKUP, fill_text[2], fill_len[2], pick_score());
        issue(OP_UNUSED, fill_text[1], fill_len[1], pick_score());
        // A difference in a byte beyond the length still means no match.
        issue(OP_LOOKUP, fill_text[6] ^ (KEY_W'(1) << 63), fill_len[6], pick_score());
        // Removing the first entry moves every other one down.
        issue(OP_DELETE, fill_text[0], fill_len[0], pick_score());
        issue(OP_DELETE, fill_text[TABLE_DEPTH-1], fill_len[TABLE_DEPTH-1], pick_score());
        issue(OP_DELETE, fill_text[TABLE_DEPTH-1], fill_len[TABLE_DEPTH-1], pick_score());
        issue(OP_LOOKUP, fill_text[7], fill_len[7], pick_score());

        // Random part in blocks of 100 transactions. The operation mix rotates
        // so the table swings between empty and full, and every fourth block
        // runs with start held high, but for the drains that fall in it.
        for (int unsigned n = 0; n < RANDOM_OPS; n++)
        begin
            block = n / 100;
            pick_key(text, len);
            issue(pick_op(block % 3), text, len, pick_score());
            if (n % 250 == 249)
                drain();
            else if (block % 4 != 3)
                idle(pick_gap());
        end

        // Wait for the last results, then allow a full scan and shift on top.
        drain();
        repeat (2 * TABLE_DEPTH + 4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // The slowest correct run takes well under 4 ms; a stuck
    // handshake or a lost result ends here.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
